FILE: rtl/core/mafu_pkg.sv
// mafu_pkg: shared widths, register indexes, sequencer step codes and the
// microcode table of the moving average filter unit.
// No dependencies.
`timescale 1ns / 1ps

package mafu_pkg;

   localparam int TIME_W     = 32;
   localparam int SAMPLE_W   = 16;
   localparam int MEAN_W     = 24;
   localparam int FRAC_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int QCNT_W     = 5;

   localparam logic [CSR_IDX_W-1:0]  CSR_WINDOW_LENGTH       = 2'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_AVERAGE_DURING_FILL = 2'd1;
   localparam logic [CSR_DATA_W-1:0] WINDOW_LENGTH_RESET     = 9'd8;
   localparam logic [QCNT_W-1:0]     QUOT_LAST_BIT           = 5'(MEAN_W - 1);

   typedef logic [2:0] step_type;

   localparam step_type STEP_ACCEPT   = 3'd0;
   localparam step_type STEP_UPDATE   = 3'd1;
   localparam step_type STEP_DIV_INIT = 3'd2;
   localparam step_type STEP_DIV_STEP = 3'd3;
   localparam step_type STEP_FINISH   = 3'd4;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_NO_REQ,
      COND_NO_EMIT,
      COND_DIV_MORE,
      COND_RSP_BUSY
   } cond_type;

   typedef struct packed {
      logic     req_ready;
      logic     do_update;
      logic     do_div_init;
      logic     do_div_step;
      logic     do_finish;
      cond_type cond;
      step_type jump_step;
      step_type next_step;
   } uword_type;

   // Program: take a beat, update window, then, if a mean is due, divide and emit.
   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      w = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_NONE, STEP_ACCEPT, STEP_ACCEPT};
      case (step)
         STEP_ACCEPT: begin
            w.req_ready = 1'b1;
            w.cond      = COND_NO_REQ;
            w.jump_step = STEP_ACCEPT;
            w.next_step = STEP_UPDATE;
         end
         STEP_UPDATE: begin
            w.do_update = 1'b1;
            w.cond      = COND_NO_EMIT;
            w.jump_step = STEP_ACCEPT;
            w.next_step = STEP_DIV_INIT;
         end
         STEP_DIV_INIT: begin
            w.do_div_init = 1'b1;
            w.next_step   = STEP_DIV_STEP;
         end
         STEP_DIV_STEP: begin
            w.do_div_step = 1'b1;
            w.cond        = COND_DIV_MORE;
            w.jump_step   = STEP_DIV_STEP;
            w.next_step   = STEP_FINISH;
         end
         STEP_FINISH: begin
            w.do_finish = 1'b1;
            w.cond      = COND_RSP_BUSY;
            w.jump_step = STEP_FINISH;
            w.next_step = STEP_ACCEPT;
         end
         default: begin
            w.next_step = STEP_ACCEPT;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/mafu_req_if.sv
// mafu_req_if: sample channel (valid/ready plus sample payload).
// Depends on mafu_pkg.
`timescale 1ns / 1ps

interface mafu_req_if import mafu_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       series_start;
   logic [TIME_W-1:0]          time_ms;
   logic signed [SAMPLE_W-1:0] sample_value;

   modport source (output valid, series_start, time_ms, sample_value, input ready);
   modport sink   (input valid, series_start, time_ms, sample_value, output ready);
endinterface

FILE: rtl/core/mafu_rsp_if.sv
// mafu_rsp_if: result channel (valid/ready plus time stamp and mean).
// Depends on mafu_pkg.
`timescale 1ns / 1ps

interface mafu_rsp_if import mafu_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [TIME_W-1:0]        time_out;
   logic signed [MEAN_W-1:0] mean_value;

   modport source (output valid, time_out, mean_value, input ready);
   modport sink   (input valid, time_out, mean_value, output ready);
endinterface

FILE: rtl/core/mafu_ram.sv
// mafu_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`timescale 1ns / 1ps

module mafu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/moving_average_filter_unit.sv
// moving_average_filter_unit: boxcar moving average over timed samples,
// microcoded control over a ring buffer, running sum and serial divider.
// Depends on mafu_pkg, mafu_req_if, mafu_rsp_if, mafu_ram.
//
//   channel | kind       | beat / write contents
//   --------+------------+------------------------------------------------
//   req     | valid/rdy  | series_start, time_ms, sample_value
//   rsp     | valid/rdy  | time_out, mean_value (signed, 8 fraction bits)
//   csr     | write only | csr_we, csr_index, csr_wdata (window, fill mode)
//
// Sequence: a beat that yields a mean goes from accept to the result register
// through accept, window update, divider load, 24 divider steps and sign fix;
// a beat that yields nothing frees the block after accept and window update.
// The restoring divider yields one quotient bit per cycle.
// Reset is synchronous; it empties the window and restores the defaults.
// No clearing pass: window slots are only read after being written.
// A result waiting in the rsp register does not block the next req beat;
// only the final step waits for that register to free up.
`timescale 1ns / 1ps

module moving_average_filter_unit import mafu_pkg::*; #(
   parameter int WINDOW_MAX = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   mafu_req_if.sink              req_chan,
   mafu_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W = $clog2(WINDOW_MAX);          // ring slot index
   localparam int FC_W  = $clog2(WINDOW_MAX + 1);      // counts up to WINDOW_MAX
   localparam int SUM_W = SAMPLE_W + FC_W;             // running sum, signed
   localparam int CMP_W = (FC_W > CSR_DATA_W) ? FC_W : CSR_DATA_W;

   // ---------------- registers ----------------
   step_type                  pc_ff, pc_in;
   logic [CSR_DATA_W-1:0]     window_length_ff, window_length_in;
   logic                      fill_mode_ff, fill_mode_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [FC_W-1:0]           fill_ff, fill_in;
   logic [PTR_W-1:0]          ptr_ff, ptr_in;

   // Current item
   logic [TIME_W-1:0]          time_ff, time_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [PTR_W-1:0]           slot_ff, slot_in;
   logic [FC_W-1:0]            count_ff, count_in;

   // Divider: dvd_ff shifts dividend bits out and quotient bits in.
   logic [FC_W-1:0]   rem_ff, rem_in;
   logic [MEAN_W-1:0] dvd_ff, dvd_in;
   logic [QCNT_W-1:0] qcnt_ff, qcnt_in;
   logic              neg_ff, neg_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]        rsp_time_ff, rsp_time_in;
   logic signed [MEAN_W-1:0] rsp_mean_ff, rsp_mean_in;

   // ---------------- microcode ----------------
   uword_type uw;
   logic      cond_hit;
   logic      emit;
   logic      rsp_busy;
   logic      accept;

   assign uw       = ucode_rom(pc_ff);
   assign rsp_busy = rsp_valid_ff && !rsp_chan.ready;
   assign accept   = uw.req_ready && req_chan.valid;

   always_comb begin
      case (uw.cond)
         COND_NONE:     cond_hit = 1'b0;
         COND_NO_REQ:   cond_hit = !req_chan.valid;
         COND_NO_EMIT:  cond_hit = !emit;
         COND_DIV_MORE: cond_hit = (qcnt_ff != '0);
         COND_RSP_BUSY: cond_hit = rsp_busy;
         default:       cond_hit = 1'b0;
      endcase
      pc_in = cond_hit ? uw.jump_step : uw.next_step;
   end

   // ---------------- effective window ----------------
   // zero acts as one, anything past WINDOW_MAX acts as WINDOW_MAX
   logic [CMP_W-1:0] wl_cmp;
   logic [CMP_W-1:0] w_cmp;
   logic [FC_W-1:0]  win;

   always_comb begin
      wl_cmp = CMP_W'(window_length_ff);
      if (wl_cmp == '0) begin
         w_cmp = CMP_W'(1);
      end else if (wl_cmp > CMP_W'(WINDOW_MAX)) begin
         w_cmp = CMP_W'(WINDOW_MAX);
      end else begin
         w_cmp = wl_cmp;
      end
      win = FC_W'(w_cmp);
   end

   // ---------------- window store ----------------
   logic [PTR_W-1:0]    rd_slot;
   logic [SAMPLE_W-1:0] old_raw;

   always_comb begin
      if (req_chan.series_start || (FC_W'(ptr_ff) >= win)) begin
         rd_slot = '0;
      end else begin
         rd_slot = ptr_ff;
      end
   end

   mafu_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_MAX)
   ) u_window (
      .clock (clock),
      .we    (uw.do_update),
      .waddr (slot_ff),
      .wdata (sample_ff),
      .re    (accept),
      .raddr (rd_slot),
      .rdata (old_raw)
   );

   // ---------------- datapath ----------------
   logic                     full;
   logic [FC_W-1:0]          fill_p1;
   logic [FC_W-1:0]          slot_p1;
   logic signed [SUM_W-1:0]  drop;
   logic [SUM_W-1:0]         mag;
   logic [FC_W:0]            trial;
   logic                     ge;

   assign full    = (fill_ff >= win);
   assign fill_p1 = fill_ff + FC_W'(1);
   assign slot_p1 = FC_W'(slot_ff) + FC_W'(1);
   assign emit    = full || fill_mode_ff || (fill_p1 == win);
   assign drop    = full ? SUM_W'($signed(old_raw)) : '0;
   assign mag     = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign trial   = {rem_ff, dvd_ff[MEAN_W-1]};
   assign ge      = (trial >= {1'b0, count_ff});

   always_comb begin
      window_length_in = window_length_ff;
      fill_mode_in     = fill_mode_ff;
      sum_in           = sum_ff;
      fill_in          = fill_ff;
      ptr_in           = ptr_ff;
      time_in          = time_ff;
      sample_in        = sample_ff;
      slot_in          = slot_ff;
      count_in         = count_ff;
      rem_in           = rem_ff;
      dvd_in           = dvd_ff;
      qcnt_in          = qcnt_ff;
      neg_in           = neg_ff;
      rsp_valid_in     = rsp_busy;
      rsp_time_in      = rsp_time_ff;
      rsp_mean_in      = rsp_mean_ff;

      if (accept) begin
         time_in   = req_chan.time_ms;
         sample_in = req_chan.sample_value;
         slot_in   = rd_slot;
         if (req_chan.series_start) begin
            sum_in  = '0;
            fill_in = '0;
         end
      end

      if (uw.do_update) begin
         sum_in = sum_ff - drop + SUM_W'(sample_ff);
         if (full) begin
            count_in = win;
         end else begin
            fill_in  = fill_p1;
            count_in = fill_p1;
         end
         ptr_in = (slot_p1 >= win) ? '0 : PTR_W'(slot_p1);
      end

      // magnitude << 8; top part is already below the divisor
      if (uw.do_div_init) begin
         rem_in  = mag[SUM_W-1:SAMPLE_W];
         dvd_in  = {mag[SAMPLE_W-1:0], {FRAC_W{1'b0}}};
         qcnt_in = QUOT_LAST_BIT;
         neg_in  = sum_ff[SUM_W-1];
      end

      if (uw.do_div_step) begin
         rem_in  = ge ? FC_W'(trial - {1'b0, count_ff}) : FC_W'(trial);
         dvd_in  = {dvd_ff[MEAN_W-2:0], ge};
         qcnt_in = qcnt_ff - QCNT_W'(1);
      end

      if (uw.do_finish && !rsp_busy) begin
         rsp_valid_in = 1'b1;
         rsp_time_in  = time_ff;
         rsp_mean_in  = neg_ff ? $signed(-dvd_ff) : $signed(dvd_ff);
      end

      // a new window length empties the window
      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               window_length_in = csr_wdata;
               sum_in           = '0;
               fill_in          = '0;
               ptr_in           = '0;
            end
            CSR_AVERAGE_DURING_FILL: begin
               fill_mode_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff            <= STEP_ACCEPT;
         window_length_ff <= WINDOW_LENGTH_RESET;
         fill_mode_ff     <= 1'b0;
         sum_ff           <= '0;
         fill_ff          <= '0;
         ptr_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pc_ff            <= pc_in;
         window_length_ff <= window_length_in;
         fill_mode_ff     <= fill_mode_in;
         sum_ff           <= sum_in;
         fill_ff          <= fill_in;
         ptr_ff           <= ptr_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      time_ff     <= time_in;
      sample_ff   <= sample_in;
      slot_ff     <= slot_in;
      count_ff    <= count_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      qcnt_ff     <= qcnt_in;
      neg_ff      <= neg_in;
      rsp_time_ff <= rsp_time_in;
      rsp_mean_ff <= rsp_mean_in;
   end

   assign req_chan.ready      = uw.req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.time_out   = rsp_time_ff;
   assign rsp_chan.mean_value = rsp_mean_ff;

endmodule

FILE: rtl/core/mafu_checker.sv
// mafu_checker: port-level assertions for moving_average_filter_unit,
// bound to the top level. Depends on mafu_pkg.
`timescale 1ns / 1ps

module mafu_checker import mafu_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [TIME_W-1:0]        rsp_time_out,
   input logic signed [MEAN_W-1:0] rsp_mean_value
);

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_time_out)
                                  && $stable(rsp_mean_value))
      else $error("rsp beat changed while stalled");

   // nothing comes out right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // one sample at a time: ready drops after a taken beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while a sample is in work");

   // a result is only loaded from the final step, never while idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while sequencer idle");

endmodule

bind moving_average_filter_unit mafu_checker u_mafu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_time_out   (rsp_chan.time_out),
   .rsp_mean_value (rsp_chan.mean_value)
);
